### sv/cubic_bspline_grid_weight_assert.svh
// Assertion macros for the cubic B-spline weight RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef CUBIC_BSPLINE_GRID_WEIGHT_ASSERT_SVH
`define CUBIC_BSPLINE_GRID_WEIGHT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBGW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBGW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/cbgw_pkg.sv
// Package for the cubic B-spline grid weight block: field widths, limits
// and the stage enable bundle. Depends on nothing.
package cbgw_pkg;

	// Fixed field widths of the streams and the register.
	localparam int POS_W = 32;
	localparam int INV_W = 24;
	localparam int W_W   = 16;
	localparam int G_W   = 18;
	localparam int OUT_W = W_W + 3 * G_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	// Pipeline depth: per-axis spline stages, then the product stages.
	localparam int AXIS_STAGES = 7;
	localparam int COMB_STAGES = 3;
	localparam int N_STAGES    = AXIS_STAGES + COMB_STAGES;

	// Register value after reset: a grid spacing of 1.0 in Q8.16.
	localparam logic [INV_W-1:0] INV_RESET = 24'd65536;

	// Output saturation limits.
	localparam logic [31:0]        W_MAX = 32'd65535;
	localparam logic signed [31:0] G_MAX = 32'sd131071;
	localparam logic signed [31:0] G_MIN = -32'sd131072;

	// Load enables, one per pipeline stage register.
	typedef struct packed {
		logic [COMB_STAGES-1:0] comb;
		logic [AXIS_STAGES-1:0] axis;
	} pipe_en_t;

endpackage

### sv/cbgw_ctrl.sv
// Pipeline control for the cubic B-spline weight block: per-stage valid
// bits and load enables. Depends on cbgw_pkg and the assertion header.
`include "cubic_bspline_grid_weight_assert.svh"

module cbgw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output cbgw_pkg::pipe_en_t en
);
	import cbgw_pkg::*;

	logic [N_STAGES:1]   valid_q;
	logic [N_STAGES+1:1] rdy;
	logic [N_STAGES:0]   up_valid;
	logic [N_STAGES:1]   en_all;
	logic                in_xfer;
	logic                out_xfer;

	// A stage can take new data when it is empty or its content moves on.
	assign rdy[N_STAGES+1] = out_ready;
	assign up_valid[0] = in_valid;
	for (genvar k = 1; k <= N_STAGES; k++) begin : g_stage
		assign rdy[k]      = !valid_q[k] || rdy[k+1];
		assign up_valid[k] = valid_q[k];
		assign en_all[k]   = rdy[k] && up_valid[k-1];
	end

	assign en.axis = en_all[AXIS_STAGES:1];
	assign en.comb = en_all[N_STAGES:AXIS_STAGES+1];

	assign in_ready  = rdy[1];
	assign out_valid = valid_q[N_STAGES];
	assign in_xfer   = in_valid && rdy[1];
	assign out_xfer  = valid_q[N_STAGES] && out_ready;

	// Valid bits move forward with the data wherever a stage is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= N_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= up_valid[k-1];
				end
			end
		end
	end

	// The item count in flight changes only by transfers at the two ends.
	`CBGW_ASSERT_NXT(a_occupancy, 1'b1, $countones(valid_q) == $past($countones(valid_q)) + int'($past(in_xfer)) - int'($past(out_xfer)), "pipeline lost or duplicated an item")
	// A full pipeline with a stalled output cannot take an input.
	`CBGW_ASSERT_IMP(a_full_stall, (&valid_q) && !out_ready, !in_ready, "input taken while pipeline full and stalled")
	// The first stage keeps its item while the second stage is blocked.
	`CBGW_ASSERT_NXT(a_hold_first, valid_q[1] && !rdy[2], valid_q[1], "first stage dropped a stalled item")

endmodule

### sv/cbgw_axis.sv
// One axis of the cubic B-spline evaluation: offset, |d|, square, cube,
// spline value and derivative over seven stages. Depends on cbgw_pkg.
module cbgw_axis #(
	parameter int FRAC_BITS = 16,
	parameter int CELL_BITS = 12
) (
	input  logic                            clk,
	input  cbgw_pkg::pipe_en_t              en,
	input  logic signed [cbgw_pkg::POS_W-1:0] pos,
	input  logic [CELL_BITS-1:0]            node_idx,
	input  logic [cbgw_pkg::INV_W-1:0]      inv_spacing,
	output logic [FRAC_BITS:0]              n,
	output logic signed [FRAC_BITS+3:0]     dn
);
	import cbgw_pkg::*;

	localparam int PROD_W = POS_W + INV_W + 1;
	localparam int D_W    = PROD_W + 1;
	localparam int X_W    = FRAC_BITS + 1;
	localparam int XX_W   = 2 * X_W;
	localparam int DER_W  = FRAC_BITS + 4;
	localparam int NS_W   = FRAC_BITS + 5;
	localparam int NUM_W  = FRAC_BITS + 3;
	localparam int HALF_W = FRAC_BITS + 2;
	localparam int DIV_K  = HALF_W + 2;
	localparam int DP_W   = HALF_W + DIV_K;
	localparam int N_W    = FRAC_BITS + 1;

	localparam logic [D_W-1:0]  ONE_D = D_W'(1) << FRAC_BITS;
	localparam logic [D_W-1:0]  TWO_D = ONE_D << 1;
	localparam logic [XX_W-1:0] RND_X = XX_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [DER_W-1:0] DER_ONE = DER_W'(1);
	localparam logic signed [NS_W-1:0]  NS_FOUR = NS_W'(64'd4 << FRAC_BITS);
	localparam logic [NUM_W-1:0] NUM_THREE = NUM_W'(3);
	// Reciprocal of three, exact for every numerator below 2^HALF_W.
	localparam logic [DIV_K-1:0] DIV3_M = DIV_K'(((64'd1 << DIV_K) + 64'd2) / 64'd3);

	// Stage registers.
	logic signed [PROD_W-1:0] prod_s1;
	logic [CELL_BITS-1:0]     cell_s1;
	logic signed [D_W-1:0]    d_s2;
	logic [X_W-1:0]           x_s3, x_s4;
	logic                     neg_s3, neg_s4;
	logic                     inner_s3, inner_s4, inner_s5;
	logic                     out_s3, out_s4, out_s5, out_s6;
	logic [X_W-1:0]           sq_s4, sq_s5;
	logic [X_W-1:0]           cu_s5;
	logic signed [DER_W-1:0]  der_s5, der_s6;
	logic [HALF_W-1:0]        half_s6;
	logic [N_W-1:0]           n_s7;
	logic signed [DER_W-1:0]  dn_s7;

	// Stage 1: scale the position into grid units.
	always_ff @(posedge clk) begin
		if (en.axis[0]) begin
			prod_s1 <= PROD_W'(pos) * PROD_W'($signed({1'b0, inv_spacing}));
			cell_s1 <= node_idx;
		end
	end

	// Stage 2: floor to the fraction grid and subtract the node position.
	logic signed [D_W-1:0] cell_term_c;
	assign cell_term_c = D_W'($signed({1'b0, cell_s1, {FRAC_BITS{1'b0}}}));

	always_ff @(posedge clk) begin
		if (en.axis[1]) begin
			d_s2 <= D_W'(prod_s1 >>> FRAC_BITS) - cell_term_c;
		end
	end

	// Stage 3: magnitude, support test and the spline argument (a or 2-a).
	logic           neg_c, inner_c, out_c;
	logic [D_W-1:0] mag_c, tmag_c;
	assign neg_c   = d_s2[D_W-1];
	assign mag_c   = neg_c ? unsigned'(-d_s2) : unsigned'(d_s2);
	assign tmag_c  = TWO_D - mag_c;
	assign inner_c = mag_c < ONE_D;
	assign out_c   = mag_c >= TWO_D;

	always_ff @(posedge clk) begin
		if (en.axis[2]) begin
			x_s3     <= inner_c ? mag_c[X_W-1:0] : tmag_c[X_W-1:0];
			neg_s3   <= neg_c;
			inner_s3 <= inner_c;
			out_s3   <= out_c;
		end
	end

	// Stage 4: rounded square of the argument.
	logic [XX_W-1:0] xx_c, sq_rnd_c;
	assign xx_c     = XX_W'(x_s3) * XX_W'(x_s3);
	assign sq_rnd_c = xx_c + RND_X;

	always_ff @(posedge clk) begin
		if (en.axis[3]) begin
			sq_s4    <= X_W'(sq_rnd_c >> FRAC_BITS);
			x_s4     <= x_s3;
			neg_s4   <= neg_s3;
			inner_s4 <= inner_s3;
			out_s4   <= out_s3;
		end
	end

	// Stage 5: rounded cube and the signed derivative.
	logic [XX_W-1:0]         sx_c, cu_rnd_c;
	logic signed [DER_W-1:0] sqe_c, xe_c, di_c, do_c, dm_c, ds_c;
	assign sx_c     = XX_W'(sq_s4) * XX_W'(x_s4);
	assign cu_rnd_c = sx_c + RND_X;
	assign sqe_c    = $signed(DER_W'(sq_s4));
	assign xe_c     = $signed(DER_W'(x_s4));
	assign di_c     = ((sqe_c <<< 1) + sqe_c - (xe_c <<< 2) + DER_ONE) >>> 1;
	assign do_c     = -((sqe_c + DER_ONE) >>> 1);
	assign dm_c     = inner_s4 ? di_c : do_c;
	assign ds_c     = neg_s4 ? -dm_c : dm_c;

	always_ff @(posedge clk) begin
		if (en.axis[4]) begin
			cu_s5    <= X_W'(cu_rnd_c >> FRAC_BITS);
			sq_s5    <= sq_s4;
			der_s5   <= out_s4 ? '0 : ds_c;
			inner_s5 <= inner_s4;
			out_s5   <= out_s4;
		end
	end

	// Stage 6: numerator of the spline value, halved ahead of the divide by three.
	logic signed [NS_W-1:0] sqs_c, cus_c, ni_c, nc_c;
	logic [NUM_W-1:0]       num_c;
	assign sqs_c = $signed(NS_W'(sq_s5));
	assign cus_c = $signed(NS_W'(cu_s5));
	assign ni_c  = (cus_c <<< 1) + cus_c - ((sqs_c <<< 2) + (sqs_c <<< 1)) + NS_FOUR;
	assign nc_c  = ni_c[NS_W-1] ? '0 : ni_c;
	assign num_c = inner_s5 ? NUM_W'(unsigned'(nc_c)) + NUM_THREE
	                        : NUM_W'(cu_s5) + NUM_THREE;

	always_ff @(posedge clk) begin
		if (en.axis[5]) begin
			half_s6 <= HALF_W'(num_c >> 1);
			der_s6  <= der_s5;
			out_s6  <= out_s5;
		end
	end

	// Stage 7: divide by three through the reciprocal; zero outside the support.
	logic [DP_W-1:0] dp_c;
	assign dp_c = DP_W'(half_s6) * DP_W'(DIV3_M);

	always_ff @(posedge clk) begin
		if (en.axis[6]) begin
			n_s7  <= out_s6 ? '0 : N_W'(dp_c >> DIV_K);
			dn_s7 <= der_s6;
		end
	end

	assign n  = n_s7;
	assign dn = dn_s7;

endmodule

### sv/cbgw_comb.sv
// Weight and gradient products of the three axis results, rounded and
// saturated over three stages. Depends on cbgw_pkg.
module cbgw_comb #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  cbgw_pkg::pipe_en_t             en,
	input  logic [FRAC_BITS:0]             n0,
	input  logic [FRAC_BITS:0]             n1,
	input  logic [FRAC_BITS:0]             n2,
	input  logic signed [FRAC_BITS+3:0]    dn0,
	input  logic signed [FRAC_BITS+3:0]    dn1,
	input  logic signed [FRAC_BITS+3:0]    dn2,
	output logic [cbgw_pkg::W_W-1:0]       weight,
	output logic signed [cbgw_pkg::G_W-1:0] grad_x,
	output logic signed [cbgw_pkg::G_W-1:0] grad_y,
	output logic signed [cbgw_pkg::G_W-1:0] grad_z
);
	import cbgw_pkg::*;

	localparam int N_W   = FRAC_BITS + 1;
	localparam int DER_W = FRAC_BITS + 4;
	localparam int P_W   = N_W + DER_W + 1;
	localparam logic [P_W-1:0]        RND_U = P_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [P_W-1:0] RND_S = P_W'(1) << (FRAC_BITS - 1);

	// Product of two unsigned spline values, rounded half up.
	function automatic logic [N_W-1:0] wmul(input logic [N_W-1:0] a, input logic [N_W-1:0] b);
		logic [P_W-1:0] p;
		p = P_W'(a) * P_W'(b);
		return N_W'((p + RND_U) >> FRAC_BITS);
	endfunction

	// Signed derivative term times a spline value, rounded half up.
	function automatic logic signed [DER_W-1:0] rmul(input logic signed [DER_W-1:0] a,
			input logic [N_W-1:0] b);
		logic signed [P_W-1:0] p;
		p = $signed(P_W'(a)) * $signed(P_W'(b));
		return DER_W'((p + RND_S) >>> FRAC_BITS);
	endfunction

	// Clamp a gradient to the output range.
	function automatic logic signed [G_W-1:0] gsat(input logic signed [DER_W-1:0] g);
		logic signed [31:0] ge;
		ge = 32'(g);
		if (ge > G_MAX) begin
			return G_W'(G_MAX);
		end else if (ge < G_MIN) begin
			return G_W'(G_MIN);
		end
		return G_W'(ge);
	endfunction

	logic [N_W-1:0]          w_s8, n0_s8, n2_s8, w_s9;
	logic signed [DER_W-1:0] g0_s8, g1_s8, g2_s8, g0_s9, g1_s9, g2_s9;
	logic [W_W-1:0]          weight_s10;
	logic signed [G_W-1:0]   gx_s10, gy_s10, gz_s10;
	logic [31:0]             we_c;

	// Stage 8: first pairwise products.
	always_ff @(posedge clk) begin
		if (en.comb[0]) begin
			w_s8  <= wmul(n0, n1);
			g0_s8 <= rmul(dn0, n1);
			g1_s8 <= rmul(dn1, n0);
			g2_s8 <= rmul(dn2, n1);
			n0_s8 <= n0;
			n2_s8 <= n2;
		end
	end

	// Stage 9: multiply in the remaining spline value.
	always_ff @(posedge clk) begin
		if (en.comb[1]) begin
			w_s9  <= wmul(w_s8, n2_s8);
			g0_s9 <= rmul(g0_s8, n2_s8);
			g1_s9 <= rmul(g1_s8, n2_s8);
			g2_s9 <= rmul(g2_s8, n0_s8);
		end
	end

	// Stage 10: saturate into the output register.
	assign we_c = 32'(w_s9);

	always_ff @(posedge clk) begin
		if (en.comb[2]) begin
			weight_s10 <= (we_c > W_MAX) ? W_W'(W_MAX) : we_c[W_W-1:0];
			gx_s10     <= gsat(g0_s9);
			gy_s10     <= gsat(g1_s9);
			gz_s10     <= gsat(g2_s9);
		end
	end

	assign weight = weight_s10;
	assign grad_x = gx_s10;
	assign grad_y = gy_s10;
	assign grad_z = gz_s10;

endmodule

### sv/cubic_bspline_grid_weight.sv
// Channel   Direction  Handshake                      Payload
// cfg       in         cfg_valid / cfg_ready          inv_spacing (Q8.16)
// s_axis    in         s_axis_tvalid / s_axis_tready  positions and node indices
// m_axis    out        m_axis_tvalid / m_axis_tready  weight and gradient
//
// Ten pipeline stages: an item enters whenever s_axis_tready is high, and its
// result is offered on m_axis once it reaches the last stage; one result per
// cycle is sustained while m_axis_tready stays high.
// The depth is set by the per-axis chain of multiplies (scale, square, cube,
// divide by three), two rounds of weight products and a saturation stage.
// A stalled output holds only the stages that are full; empty stages upstream
// keep filling, so the input stalls only when the whole pipeline is full.
// Reset clears all valid bits and sets inv_spacing to 1.0.
//
// Top level of the cubic B-spline grid weight block. Depends on cbgw_pkg,
// cbgw_ctrl, cbgw_axis and cbgw_comb.
module cubic_bspline_grid_weight #(
	parameter int FRAC_BITS = 16,
	parameter int CELL_BITS = 12,
	localparam int IN_TW = ((3 * cbgw_pkg::POS_W + 3 * CELL_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cbgw_pkg::INV_W-1:0]     cfg_data,
	// Input stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// Fields from bit 0: pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, zero pad.
	input  logic [IN_TW-1:0]               s_axis_tdata,
	// Output stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// Fields from bit 0: weight, grad_x, grad_y, grad_z, zero pad.
	output logic [cbgw_pkg::OUT_TW-1:0]    m_axis_tdata
);
	import cbgw_pkg::*;

	localparam int CELL_LO = 3 * POS_W;

	logic [INV_W-1:0]          inv_spacing_q;
	pipe_en_t                  en;
	logic [FRAC_BITS:0]        n_x, n_y, n_z;
	logic signed [FRAC_BITS+3:0] dn_x, dn_y, dn_z;
	logic [W_W-1:0]            weight;
	logic signed [G_W-1:0]     grad_x, grad_y, grad_z;

	// Configuration register; a write is always taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_spacing_q <= INV_RESET;
		end else if (cfg_valid) begin
			inv_spacing_q <= cfg_data;
		end
	end

	// Valid bits and stage enables.
	cbgw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.en        (en)
	);

	// One spline pipeline per axis.
	cbgw_axis #(.FRAC_BITS(FRAC_BITS), .CELL_BITS(CELL_BITS)) u_axis_x (
		.clk         (clk),
		.en          (en),
		.pos         ($signed(s_axis_tdata[0 +: POS_W])),
		.node_idx    (s_axis_tdata[CELL_LO +: CELL_BITS]),
		.inv_spacing (inv_spacing_q),
		.n           (n_x),
		.dn          (dn_x)
	);

	cbgw_axis #(.FRAC_BITS(FRAC_BITS), .CELL_BITS(CELL_BITS)) u_axis_y (
		.clk         (clk),
		.en          (en),
		.pos         ($signed(s_axis_tdata[POS_W +: POS_W])),
		.node_idx    (s_axis_tdata[CELL_LO + CELL_BITS +: CELL_BITS]),
		.inv_spacing (inv_spacing_q),
		.n           (n_y),
		.dn          (dn_y)
	);

	cbgw_axis #(.FRAC_BITS(FRAC_BITS), .CELL_BITS(CELL_BITS)) u_axis_z (
		.clk         (clk),
		.en          (en),
		.pos         ($signed(s_axis_tdata[2 * POS_W +: POS_W])),
		.node_idx    (s_axis_tdata[CELL_LO + 2 * CELL_BITS +: CELL_BITS]),
		.inv_spacing (inv_spacing_q),
		.n           (n_z),
		.dn          (dn_z)
	);

	// Weight and gradient products.
	cbgw_comb #(.FRAC_BITS(FRAC_BITS)) u_comb (
		.clk    (clk),
		.en     (en),
		.n0     (n_x),
		.n1     (n_y),
		.n2     (n_z),
		.dn0    (dn_x),
		.dn1    (dn_y),
		.dn2    (dn_z),
		.weight (weight),
		.grad_x (grad_x),
		.grad_y (grad_y),
		.grad_z (grad_z)
	);

	// Pack the result, padding the top bits with zeros.
	assign m_axis_tdata = {(OUT_TW - OUT_W)'(0), grad_z, grad_y, grad_x, weight};

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the cubic B-spline grid weight block.
// Needs cbgw_pkg and the cubic_bspline_grid_weight RTL; drives random traffic with
// stalls on both streams; checks each result against a predictor or known value.
module tb;

	localparam int FRAC = 16;
	localparam int CELLW = 12;
	localparam int IN_TW = ((3 * 32 + 3 * CELLW + 7) / 8) * 8;
	localparam longint ONE = 64'sd1 <<< FRAC;
	localparam int WDOG_LIMIT = 2000;
	localparam int RAND_PER_SETTING = 320;
	localparam int N_SETTINGS = 6;
	localparam int LONG_HOLD = 90;

	// One particle/node pair; the last field, pos, sits in the lowest bits.
	typedef struct packed {
		logic [2:0][CELLW-1:0] node_idx;
		logic [2:0][31:0]      pos;
	} particle_t;

	// One weight and gradient result, packed as on the output stream.
	typedef struct packed {
		logic signed [17:0] grad_z;
		logic signed [17:0] grad_y;
		logic signed [17:0] grad_x;
		logic [15:0]        weight;
	} node_weight_t;

	typedef struct {
		particle_t    p;
		bit           known;
		node_weight_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [cbgw_pkg::INV_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// Fields from bit 0: pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, zero pad.
	logic [IN_TW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// Fields from bit 0: weight, grad_x, grad_y, grad_z, zero pad.
	logic [cbgw_pkg::OUT_TW-1:0] m_axis_tdata;

	logic [cbgw_pkg::INV_W-1:0] spacing_shadow = cbgw_pkg::INV_RESET;
	node_weight_t pending_weights[$];
	stim_row_t directed_rows[$];
	node_weight_t got_res;
	node_weight_t want_res;
	int error_count = 0;
	int results_checked = 0;
	int particles_sent = 0;
	int settings_used = 0;
	int quiet_cycles = 0;
	int hold_request = 0;
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;

	cubic_bspline_grid_weight u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Product of two Q.16 terms, rounded half up.
	function automatic longint round_q(longint v);
		return (v + (ONE >>> 1)) >>> FRAC;
	endfunction

	function automatic longint triple_q(longint a, longint b, longint c);
		return round_q(round_q(a * b) * c);
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Spline value and derivative for one signed Q.16 offset.
	function automatic void spline_eval(input longint d, output longint n, output longint dn);
		longint a, sq, cu, num, t, tsq, tcu, der;
		a = (d < 0) ? -d : d;
		n = 0;
		dn = 0;
		if (a < ONE) begin
			sq = round_q(a * a);
			cu = round_q(sq * a);
			num = 3 * cu - 6 * sq + 4 * ONE;
			if (num < 0)
				num = 0;
			n = (num + 3) / 6;
			der = (3 * sq - 4 * a + 1) >>> 1;
			dn = (d < 0) ? -der : der;
		end else if (a < 2 * ONE) begin
			t = 2 * ONE - a;
			tsq = round_q(t * t);
			tcu = round_q(tsq * t);
			n = (tcu + 3) / 6;
			der = -((tsq + 1) >>> 1);
			dn = (d < 0) ? -der : der;
		end
	endfunction

	// Expected weight and gradient of one particle at the current spacing.
	function automatic node_weight_t predict_weight_grad(particle_t p, logic [23:0] inv);
		longint n[3];
		longint dn[3];
		longint d;
		node_weight_t r;
		int i;
		for (i = 0; i < 3; i++) begin
			d = ((longint'($signed(p.pos[i])) * longint'(inv)) >>> FRAC)
				- (longint'(p.node_idx[i]) <<< FRAC);
			spline_eval(d, n[i], dn[i]);
		end
		r.weight = 16'(sat(triple_q(n[0], n[1], n[2]), 0, 65535));
		r.grad_x = 18'(sat(triple_q(dn[0], n[1], n[2]), -131072, 131071));
		r.grad_y = 18'(sat(triple_q(dn[1], n[0], n[2]), -131072, 131071));
		r.grad_z = 18'(sat(triple_q(dn[2], n[1], n[0]), -131072, 131071));
		return r;
	endfunction

	// Random particle: mostly placed so each offset lands near the spline support.
	function automatic particle_t make_particle(logic [23:0] inv);
		particle_t p;
		longint dt, tgt, pl;
		int i, cl;
		bit wild_item;
		wild_item = ($urandom_range(0, 7) == 0);
		for (i = 0; i < 3; i++) begin
			if (wild_item || $urandom_range(0, 7) == 0) begin
				p.pos[i] = $urandom;
				p.node_idx[i] = CELLW'($urandom_range(0, 4095));
			end else begin
				cl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 4095);
				dt = longint'($urandom_range(0, 300000)) - 150000;
				if (inv == 0) begin
					// Offset is just minus the node index here.
					cl = $urandom_range(0, 2);
					pl = longint'($signed($urandom));
				end else begin
					tgt = (longint'(cl) <<< FRAC) + dt;
					pl = (tgt <<< FRAC) / longint'(inv);
					if (pl > 64'sd2147483647 || pl < -64'sd2147483648) begin
						cl = 0;
						pl = (dt <<< FRAC) / longint'(inv);
					end
					if (pl > 64'sd2147483647 || pl < -64'sd2147483648)
						pl = longint'($signed($urandom));
				end
				p.pos[i] = pl[31:0];
				p.node_idx[i] = cl[CELLW-1:0];
			end
		end
		return p;
	endfunction

	function automatic void add_row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [11:0] cx, logic [11:0] cy, logic [11:0] cz, bit known, int w);
		stim_row_t row;
		row.p.pos[0] = px;
		row.p.pos[1] = py;
		row.p.pos[2] = pz;
		row.p.node_idx[0] = cx;
		row.p.node_idx[1] = cy;
		row.p.node_idx[2] = cz;
		row.known = known;
		row.res = '0;
		row.res.weight = 16'(w);
		directed_rows.push_back(row);
	endfunction

	// Offer one particle, wait for its transfer and record what it should produce.
	task automatic send_particle(stim_row_t row);
		int gap;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TW'(row.p);
		do @(posedge clk); while (!s_axis_tready);
		pending_weights.push_back(row.known ? row.res : predict_weight_grad(row.p, spacing_shadow));
		particles_sent++;
		@(negedge clk);
	endtask

	// Change the spacing only once the pipeline has drained.
	task automatic write_spacing(logic [23:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_weights.size() != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		spacing_shadow = v;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_request - 1) @(negedge clk);
				hold_request = 0;
			end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				m_axis_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare every output transfer with the oldest pending expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = m_axis_tdata[cbgw_pkg::OUT_W-1:0];
			if (pending_weights.size() == 0) begin
				$error("Unexpected result transfer: %h", m_axis_tdata);
				error_count++;
			end else begin
				want_res = pending_weights.pop_front();
				results_checked++;
				if (got_res.weight !== want_res.weight) begin
					$error("weight: expected %0d, got %0d", want_res.weight, got_res.weight);
					error_count++;
				end
				if (got_res.grad_x !== want_res.grad_x) begin
					$error("grad_x: expected %0d, got %0d", want_res.grad_x, got_res.grad_x);
					error_count++;
				end
				if (got_res.grad_y !== want_res.grad_y) begin
					$error("grad_y: expected %0d, got %0d", want_res.grad_y, got_res.grad_y);
					error_count++;
				end
				if (got_res.grad_z !== want_res.grad_z) begin
					$error("grad_z: expected %0d, got %0d", want_res.grad_z, got_res.grad_z);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no transfer happens for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [23:0] spacing_plan [N_SETTINGS];
		stim_row_t row;
		int s, k;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		spacing_plan = '{24'd1, 24'hFFFFFF, 24'd0, 24'd65536, 24'd32768, 24'd65536};
		spacing_plan[3] = 24'($urandom_range(1, 24'hFFFFFF));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows at the reset spacing of 1.0. Zero offsets on every axis
		// give the peak weight; offsets at or beyond two cells give all zeros.
		add_row(0, 0, 0, 0, 0, 0, 1'b1, 19419);
		add_row(268369920, 268369920, 268369920, 12'd4095, 12'd4095, 12'd4095, 1'b1, 19419);
		add_row(178913280, 89456640, 0, 12'hAAA, 12'h555, 12'd0, 1'b1, 19419);
		add_row(0, 0, 0, 12'd4095, 12'd4095, 12'd4095, 1'b1, 0);
		add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 1'b1, 0);
		add_row(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 1'b1, 0);
		add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 12'd4095, 12'd4095, 12'd4095,
			1'b1, 0);
		add_row(131072, 0, 0, 0, 0, 0, 1'b1, 0);
		add_row(0, -32'sd131072, 0, 0, 0, 0, 1'b1, 0);
		// Segment boundaries and points just inside the support.
		add_row(65536, -32'sd65536, 0, 0, 0, 0, 1'b0, 0);
		add_row(131071, -32'sd131071, 0, 0, 0, 0, 1'b0, 0);
		add_row(1, -32'sd1, 65535, 0, 0, 0, 1'b0, 0);
		add_row(32768, -32'sd32768, 98304, 0, 0, 0, 1'b0, 0);
		add_row(-32'sd98304, 65535, -32'sd65537, 0, 0, 0, 1'b0, 0);
		add_row(134257728, 6483600, 268469920, 12'd2048, 12'd100, 12'd4095, 1'b0, 0);
		add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 1'b0, 0);
		add_row(32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 12'h555, 12'hAAA, 12'hF0F, 1'b0, 0);
		add_row(-32'sd65536, -32'sd131071, -32'sd1, 0, 0, 0, 1'b0, 0);
		foreach (directed_rows[k])
			send_particle(directed_rows[k]);

		// Random traffic under each spacing setting.
		for (s = 0; s < N_SETTINGS; s++) begin
			write_spacing(spacing_plan[s]);
			if (s == 1)
				hold_request = LONG_HOLD;
			if (s == N_SETTINGS - 1) begin
				src_idle_on = 1'b0;
				snk_idle_on = 1'b0;
			end
			for (k = 0; k < RAND_PER_SETTING; k++) begin
				row.p = make_particle(spacing_shadow);
				row.known = 1'b0;
				row.res = '0;
				send_particle(row);
			end
		end

		// Drain, then allow for any stray output.
		s_axis_tvalid <= 1'b0;
		while (pending_weights.size() != 0)
			@(negedge clk);
		repeat (cbgw_pkg::N_STAGES + 4) @(negedge clk);

		$display("Checked %0d results from %0d particles over %0d spacing settings.",
			results_checked, particles_sent, settings_used + 1);
		$display("Covered both spline segments, out-of-support offsets and a long output stall.");
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
